// File: design/scfp_pkg.sv
// Shared types, constants and functions of the synthesizer channel frequency planner.
`timescale 1ns / 1ps
`default_nettype none
package scfp_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 31;

    localparam logic [CfgIdxW-1:0] CFG_CRYSTAL = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_BASE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SPACING = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_IF = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LO_SIDE = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_FORCE_CCM = 3'd5;

    localparam logic [25:0] CRYSTAL_RST = 26'd38400000;
    localparam logic [30:0] BASE_RST = 31'd868000000;
    localparam logic [23:0] SPACING_RST = 24'd100000;
    localparam logic [22:0] IF_RST = 23'd400000;

    localparam int ScaleShift = 19;
    localparam logic [7:0] CODE_OUT_OF_BAND = 8'h03;

    localparam logic [31:0] TARGET_SPLIT = 32'h4000_0001;
    localparam logic [32:0] HALF_TARGET_LOW = 33'd1750000;
    localparam logic [32:0] HALF_TARGET_HIGH = 33'd3500000;
    localparam logic [16:0] TARGET_ODD = 17'd109375;
    localparam int RecipShift = 45;
    localparam logic [28:0] TARGET_RECIP = 29'((64'd1 << RecipShift) / 64'd109375);
    localparam logic [9:0] DIV_DCDC_MAX = 10'd1023;
    localparam logic [6:0] FRAC_SCALE = 7'd100;
    localparam logic [7:0] RCO_BAND_LOW = 8'd1;
    localparam logic [7:0] RCO_BAND_HIGH = 8'd4;

    localparam logic [63:0] DIG_STEP = 64'd625000000;
    localparam logic [63:0] DCDC_STEP = 64'd325000000;

    localparam logic [31:0] BAND_LO [14] = '{
        32'd1150000000, 32'd745000000, 32'd575000000, 32'd467000000,
        32'd358000000, 32'd292000000, 32'd260000000, 32'd234000000,
        32'd192000000, 32'd156000000, 32'd146000000, 32'd130000000,
        32'd117000000, 32'd100000000};
    localparam logic [31:0] BAND_HI [14] = '{
        32'd1450000000, 32'd956000000, 32'd745000000, 32'd575000000,
        32'd467000000, 32'd358000000, 32'd292000000, 32'd260000000,
        32'd234000000, 32'd192000000, 32'd156000000, 32'd146000000,
        32'd130000000, 32'd117000000};
    localparam logic [7:0] BAND_CODE [14] = '{
        8'h02, 8'h03, 8'h04, 8'h05, 8'h13, 8'h14, 8'h1b,
        8'h15, 8'h1c, 8'h1d, 8'h24, 8'h9b, 8'h25, 8'h9c};
    localparam logic [1:0] MMD_TABLE [10] = '{
        2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0};

    typedef struct packed {
        logic [25:0] crystal_hz;
        logic [30:0] base_freq_hz;
        logic [23:0] spacing_hz;
        logic [22:0] if_hz;
        logic        lo_side_flag;
        logic        force_ccm;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  divider_code;
        logic [25:0] freq_word;
        logic [23:0] spacing_word;
        logic [19:0] if_word;
        logic [31:0] base_q_hz;
        logic [31:0] spacing_q_hz;
    } t_plan;

    typedef struct packed {
        logic [25:0] rem;
        logic [31:0] quo;
        logic [31:0] f;
        logic [31:0] vco;
        logic [9:0]  div_dcdc;
        logic [1:0]  rs_dig;
        logic [1:0]  rs_dcdc;
        logic        thigh;
    } t_div;

    typedef struct packed {
        logic [31:0] channel_freq_hz;
        logic [9:0]  mmd_div_dcdc;
        logic [1:0]  mmd_div_rs_dig;
        logic [1:0]  mmd_div_rs_dcdc;
        logic [2:0]  retime_limit_low;
        logic [2:0]  retime_limit_high;
        logic        retime_allowed;
        logic        thigh;
    } t_res;

    function automatic logic [7:0] band_code(input logic [30:0] hz);
        logic [7:0] code;
        code = CODE_OUT_OF_BAND;
        for (int i = 13; i >= 0; i--) begin
            if ({1'b0, hz} >= BAND_LO[i] && {1'b0, hz} < BAND_HI[i]) begin
                code = BAND_CODE[i];
            end
        end
        return code;
    endfunction

    function automatic logic [8:0] decode_lodiv(input logic [7:0] code);
        logic [8:0] a;
        logic [8:0] b;
        logic [8:0] c;
        a = (code[7:6] == 2'd0) ? 9'd1 : {7'd0, code[7:6]};
        b = (code[5:3] == 3'd0) ? 9'd1 : {6'd0, code[5:3]};
        c = (code[2:0] == 3'd0) ? 9'd1 : {6'd0, code[2:0]};
        return 9'(a * b * c);
    endfunction

    // number of whole steps in vco, clipped to max_k
    function automatic logic [3:0] count_steps(input logic [31:0] vco,
                                               input logic [63:0] step,
                                               input int max_k);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 1; k <= 8; k++) begin
            if (k <= max_k && {32'd0, vco} >= 64'(k) * step) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [1:0] mmd_lookup(input logic [3:0] idx);
        return (idx > 4'd9) ? MMD_TABLE[9] : MMD_TABLE[idx];
    endfunction

    // one restoring division step on the retime divider
    function automatic t_div div_step(input t_div s, input logic [25:0] d);
        t_div       o;
        logic [26:0] rt;
        o = s;
        rt = {s.rem, s.f[31]};
        o.f = {s.f[30:0], 1'b0};
        if (rt >= {1'b0, d}) begin
            o.rem = 26'(rt - {1'b0, d});
            o.quo = {s.quo[30:0], 1'b1};
        end else begin
            o.rem = rt[25:0];
            o.quo = {s.quo[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// File: design/scfp_in_if.sv
// Channel number input channel.
`timescale 1ns / 1ps
`default_nettype none
interface scfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] channel;

    modport source(output valid, output channel, input ready);
    modport sink(input valid, input channel, output ready);
endinterface
`default_nettype wire

// File: design/scfp_out_if.sv
// Synthesizer settings result channel.
`timescale 1ns / 1ps
`default_nettype none
interface scfp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  divider_code;
    logic [25:0] freq_word;
    logic [23:0] spacing_word;
    logic [19:0] if_word;
    logic [31:0] channel_freq_hz;
    logic [9:0]  mmd_div_dcdc;
    logic [1:0]  mmd_div_rs_dig;
    logic [1:0]  mmd_div_rs_dcdc;
    logic [2:0]  retime_limit_low;
    logic [2:0]  retime_limit_high;
    logic        retime_allowed;
    logic [7:0]  rco_band;

    modport source(output valid, output divider_code, output freq_word,
        output spacing_word, output if_word, output channel_freq_hz,
        output mmd_div_dcdc, output mmd_div_rs_dig, output mmd_div_rs_dcdc,
        output retime_limit_low, output retime_limit_high,
        output retime_allowed, output rco_band, input ready);
    modport sink(input valid, input divider_code, input freq_word,
        input spacing_word, input if_word, input channel_freq_hz,
        input mmd_div_dcdc, input mmd_div_rs_dig, input mmd_div_rs_dcdc,
        input retime_limit_low, input retime_limit_high,
        input retime_allowed, input rco_band, output ready);
endinterface
`default_nettype wire

// File: design/scfp_prep.sv
// Configuration-derived band code, scaled words and quantized base and spacing hertz.
`timescale 1ns / 1ps
`default_nettype none
module scfp_prep
    import scfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_restart,
    input  wire t_cfg  i_cfg,
    output t_plan      o_plan,
    output logic       o_done
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_DIV   = 4'b0010,
        S_STORE = 4'b0100,
        S_DONE  = 4'b1000
    } t_pstate;

    localparam logic [5:0] LAST_STEP = 6'd58;

    t_pstate     r_state;
    logic [1:0]  r_sel;
    logic        r_hz;
    logic [5:0]  r_cnt;
    logic [58:0] r_num;
    logic [25:0] r_rem;
    logic [58:0] r_quo;
    logic [25:0] r_fw;
    logic [23:0] r_sw;
    logic [19:0] r_iw;
    logic [31:0] r_fq;
    logic [31:0] r_sq;

    logic [7:0]  w_code;
    logic [8:0]  w_lodiv;
    logic [30:0] w_hz;
    logic [39:0] w_wprod;
    logic [25:0] w_word;
    logic [51:0] w_hprod;
    logic [25:0] w_div;
    logic [26:0] w_remt;
    logic        w_ge;

    assign w_code = band_code(i_cfg.base_freq_hz);
    assign w_lodiv = decode_lodiv(w_code);

    always_comb begin
        unique case (r_sel)
            2'd0:    w_hz = i_cfg.base_freq_hz;
            2'd1:    w_hz = {7'd0, i_cfg.spacing_hz};
            2'd2:    w_hz = {8'd0, i_cfg.if_hz};
            default: w_hz = '0;
        endcase
        unique case (r_sel)
            2'd0:    w_word = (r_quo > 59'h3FF_FFFF) ? 26'h3FF_FFFF : r_quo[25:0];
            2'd1:    w_word = (r_quo > 59'hFF_FFFF) ? 26'hFF_FFFF : {2'd0, r_quo[23:0]};
            2'd2:    w_word = (r_quo > 59'hF_FFFF) ? 26'hF_FFFF : {6'd0, r_quo[19:0]};
            default: w_word = '0;
        endcase
    end

    assign w_wprod = 40'(w_hz) * 40'(w_lodiv);
    assign w_hprod = 52'(w_word) * 52'(i_cfg.crystal_hz);
    assign w_div = r_hz ? {17'd0, w_lodiv} : i_cfg.crystal_hz;
    assign w_remt = {r_rem, r_num[58]};
    assign w_ge = w_remt >= {1'b0, w_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_sel <= 2'd0;
            r_hz <= 1'b0;
            r_cnt <= 6'd0;
        end else if (i_restart) begin
            r_state <= S_LOAD;
            r_sel <= 2'd0;
            r_hz <= 1'b0;
            r_cnt <= 6'd0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    r_num <= {w_wprod, {ScaleShift{1'b0}}};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= 6'd0;
                    r_hz <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= {r_num[57:0], 1'b0};
                    r_rem <= w_ge ? 26'(w_remt - {1'b0, w_div}) : w_remt[25:0];
                    r_quo <= {r_quo[57:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (!r_hz) begin
                        unique case (r_sel)
                            2'd0:    r_fw <= w_word;
                            2'd1:    r_sw <= w_word[23:0];
                            default: r_iw <= w_word[19:0];
                        endcase
                        if (r_sel == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_num <= {26'd0, w_hprod[51:ScaleShift]};
                            r_rem <= '0;
                            r_quo <= '0;
                            r_cnt <= 6'd0;
                            r_hz <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end else begin
                        if (r_sel == 2'd0) begin
                            r_fq <= r_quo[31:0];
                        end else begin
                            r_sq <= r_quo[31:0];
                        end
                        r_sel <= r_sel + 2'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_DONE: r_state <= S_DONE;
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_plan.divider_code = w_code;
    assign o_plan.freq_word = r_fw;
    assign o_plan.spacing_word = r_sw;
    assign o_plan.if_word = r_iw;
    assign o_plan.base_q_hz = r_fq;
    assign o_plan.spacing_q_hz = r_sq;

endmodule
`default_nettype wire

// File: design/synth_channel_frequency_planner.sv
// Top level: channel-to-synthesizer-settings pipeline with configuration registers.
//
// Usage: write the six configuration registers through i_cfg_we/i_cfg_idx/i_cfg_data,
// then send channel numbers on i_chan; one result beat per channel beat leaves on o_res.
// After reset and after every register write, a setup sequencer computes the
// FREQ/CHSP/IFFREQ words and the quantized hertz values of FREQ and CHSP with one
// shared shift-subtract divider (five 59-step divisions plus load and store states),
// during which i_chan.ready is low. The band code is decoded combinationally.
// Per channel the datapath is a fixed pipeline: multiply-add for the channel frequency,
// a reciprocal multiply for the DCDC divider, and a 32-stage restoring divider by the
// crystal frequency for the retime limits. A new beat is accepted every cycle unless
// setup is running or the skid register holds a result.
// Results go to an output register backed by a one-entry skid register, so the pipeline
// keeps taking beats while a result waits; when both are full the whole pipeline holds
// and i_chan.ready drops until o_res.ready frees the skid entry. Nothing is dropped.
// Reset is synchronous and active low; it loads the register defaults and clears all
// valid bits.
`timescale 1ns / 1ps
`default_nettype none
module synth_channel_frequency_planner
    import scfp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    scfp_in_if.sink                  i_chan,
    scfp_out_if.source               o_res
);

    localparam int DivStages = 32;

    t_cfg        r_cfg;
    t_plan       w_plan;
    logic        w_done;

    logic        w_adv;
    logic        w_in_acc;
    logic        w_out_take;

    logic        r_s1_v;
    logic [7:0]  r_s1_ch;
    logic        r_s2_v;
    logic [31:0] r_s2_prod;
    logic        r_s3_v;
    logic [31:0] r_s3_vco;
    logic        r_s4_v;
    logic [31:0] r_s4_vco;
    logic [27:0] r_s4_y;
    logic        r_s4_thigh;
    logic [1:0]  r_s4_rs_dig;
    logic [1:0]  r_s4_rs_dcdc;
    logic        r_s5_v;
    logic [31:0] r_s5_vco;
    logic [27:0] r_s5_y;
    logic [11:0] r_s5_qe;
    logic        r_s5_thigh;
    logic [1:0]  r_s5_rs_dig;
    logic [1:0]  r_s5_rs_dcdc;

    logic        r_dv_v [DivStages+1];
    t_div        r_dv   [DivStages+1];

    logic        r_out_v;
    t_res        r_out;
    logic        r_skid_v;
    t_res        r_skid;

    logic        w_thigh;
    logic [32:0] w_x;
    logic [27:0] w_y;
    logic [56:0] w_rprod;
    logic [28:0] w_qd;
    logic [28:0] w_r;
    logic [12:0] w_q1;
    logic [12:0] w_q2;
    t_div        w_dv0;
    t_res        w_res;
    logic [32:0] w_frac;
    logic        w_frac0;
    logic [31:0] w_lim;
    logic [31:0] w_lh;
    logic [31:0] w_ll;

    scfp_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_cfg     (r_cfg),
        .o_plan    (w_plan),
        .o_done    (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crystal_hz <= CRYSTAL_RST;
            r_cfg.base_freq_hz <= BASE_RST;
            r_cfg.spacing_hz <= SPACING_RST;
            r_cfg.if_hz <= IF_RST;
            r_cfg.lo_side_flag <= 1'b0;
            r_cfg.force_ccm <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CRYSTAL:   r_cfg.crystal_hz <= i_cfg_data[25:0];
                CFG_BASE:      r_cfg.base_freq_hz <= i_cfg_data[30:0];
                CFG_SPACING:   r_cfg.spacing_hz <= i_cfg_data[23:0];
                CFG_IF:        r_cfg.if_hz <= i_cfg_data[22:0];
                CFG_LO_SIDE:   r_cfg.lo_side_flag <= i_cfg_data[0];
                CFG_FORCE_CCM: r_cfg.force_ccm <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_adv = !r_skid_v;
    assign i_chan.ready = w_adv && w_done;
    assign w_in_acc = i_chan.valid && i_chan.ready;
    assign w_out_take = r_out_v && o_res.ready;

    // stage 4 front end: retime target and table indexes
    assign w_thigh = !(r_s3_vco < TARGET_SPLIT);
    assign w_x = {1'b0, r_s3_vco} + (w_thigh ? HALF_TARGET_HIGH : HALF_TARGET_LOW);
    assign w_y = w_thigh ? {1'b0, w_x[32:6]} : w_x[32:5];

    // stage 5: quotient estimate
    assign w_rprod = 57'(r_s4_y) * 57'(TARGET_RECIP);

    // stage 6: estimate correction, then into the divider
    assign w_qd = 29'(r_s5_qe) * 29'(TARGET_ODD);
    assign w_r = {1'b0, r_s5_y} - w_qd;
    assign w_q1 = (w_r >= {12'd0, TARGET_ODD}) ? {1'b0, r_s5_qe} + 13'd1 : {1'b0, r_s5_qe};
    assign w_q2 = (w_q1 == 13'd0) ? 13'd0 : w_q1 - 13'd1;

    always_comb begin
        w_dv0.rem = '0;
        w_dv0.quo = '0;
        w_dv0.f = r_s5_vco >> r_s5_rs_dig;
        w_dv0.vco = r_s5_vco;
        w_dv0.div_dcdc = (w_q2 > {3'd0, DIV_DCDC_MAX}) ? DIV_DCDC_MAX : w_q2[9:0];
        w_dv0.rs_dig = r_s5_rs_dig;
        w_dv0.rs_dcdc = r_s5_rs_dcdc;
        w_dv0.thigh = r_s5_thigh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            for (int k = 0; k <= DivStages; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_s1_v <= w_in_acc;
            r_s1_ch <= i_chan.channel;
            r_s2_v <= r_s1_v;
            r_s2_prod <= 32'(w_plan.spacing_q_hz * 32'(r_s1_ch));
            r_s3_v <= r_s2_v;
            r_s3_vco <= r_cfg.lo_side_flag
                ? r_s2_prod + w_plan.base_q_hz - {9'd0, r_cfg.if_hz}
                : r_s2_prod + w_plan.base_q_hz + {9'd0, r_cfg.if_hz};
            r_s4_v <= r_s3_v;
            r_s4_vco <= r_s3_vco;
            r_s4_y <= w_y;
            r_s4_thigh <= w_thigh;
            r_s4_rs_dig <= mmd_lookup(count_steps(r_s3_vco, DIG_STEP, 6) + 4'd1);
            r_s4_rs_dcdc <= mmd_lookup(count_steps(r_s3_vco, DCDC_STEP, 8) + 4'd1);
            r_s5_v <= r_s4_v;
            r_s5_vco <= r_s4_vco;
            r_s5_y <= r_s4_y;
            r_s5_qe <= w_rprod[56:RecipShift];
            r_s5_thigh <= r_s4_thigh;
            r_s5_rs_dig <= r_s4_rs_dig;
            r_s5_rs_dcdc <= r_s4_rs_dcdc;
            r_dv_v[0] <= r_s5_v;
            r_dv[0] <= w_dv0;
            for (int k = 0; k < DivStages; k++) begin
                r_dv_v[k+1] <= r_dv_v[k];
                r_dv[k+1] <= div_step(r_dv[k], r_cfg.crystal_hz);
            end
        end
    end

    // retime limits from quotient and remainder
    always_comb begin
        w_frac = 33'(r_dv[DivStages].rem) * 33'(FRAC_SCALE);
        w_frac0 = (r_cfg.crystal_hz != 26'd0) && (w_frac[31:0] < {6'd0, r_cfg.crystal_hz});
        w_lim = w_frac0 ? r_dv[DivStages].quo - 32'd1 : r_dv[DivStages].quo;
        w_lh = (w_lim >> 1) - 32'd1;
        w_ll = ((w_lim + 32'd1) >> 1) - 32'd1;
        w_res.channel_freq_hz = r_dv[DivStages].vco;
        w_res.mmd_div_dcdc = r_dv[DivStages].div_dcdc;
        w_res.mmd_div_rs_dig = r_dv[DivStages].rs_dig;
        w_res.mmd_div_rs_dcdc = r_dv[DivStages].rs_dcdc;
        w_res.retime_limit_low = w_ll[2:0];
        w_res.retime_limit_high = w_lh[2:0];
        w_res.retime_allowed = (w_lh < 32'd8) && (w_ll < 32'd8)
            && ((w_lh != 32'd0) || (w_ll != 32'd0));
        w_res.thigh = r_dv[DivStages].thigh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_take) begin
                r_out <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_dv_v[DivStages]) begin
            if (!r_out_v || w_out_take) begin
                r_out <= w_res;
                r_out_v <= 1'b1;
            end else begin
                r_skid <= w_res;
                r_skid_v <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_res.valid = r_out_v;
    assign o_res.divider_code = w_plan.divider_code;
    assign o_res.freq_word = w_plan.freq_word;
    assign o_res.spacing_word = w_plan.spacing_word;
    assign o_res.if_word = w_plan.if_word;
    assign o_res.channel_freq_hz = r_out.channel_freq_hz;
    assign o_res.mmd_div_dcdc = r_out.mmd_div_dcdc;
    assign o_res.mmd_div_rs_dig = r_out.mmd_div_rs_dig;
    assign o_res.mmd_div_rs_dcdc = r_out.mmd_div_rs_dcdc;
    assign o_res.retime_limit_low = r_out.retime_limit_low;
    assign o_res.retime_limit_high = r_out.retime_limit_high;
    assign o_res.retime_allowed = r_out.retime_allowed;
    assign o_res.rco_band = !r_cfg.force_ccm ? 8'd0
        : (r_out.thigh ? RCO_BAND_HIGH : RCO_BAND_LOW);

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output beat");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_res.ready) |=> r_skid_v)
        else $error("skid entry lost while output stalled");

    a_no_accept_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_we) |-> !w_in_acc)
        else $error("channel beat taken during setup");

    a_last_stage_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[DivStages] && w_adv) |=> r_out_v)
        else $error("finished beat did not reach the output");

endmodule
`default_nettype wire
